/* sv/svg_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the sphere vertex generator.
// No dependencies.
package svg_pkg;

  localparam int FRAC_BITS  = 32;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = FRAC_BITS / DIV_STEP;
  localparam int TEX_BITS   = 16;
  localparam int TEX_STAGE  = TEX_BITS / DIV_STEP;
  localparam int DIV_LAT    = DIV_STAGES + 1;
  localparam int PLACE_LAT  = 4;
  localparam int TRIG_W     = 34;
  localparam int ANG_W      = 33;

  localparam logic signed [TRIG_W-1:0] CORDIC_INIT = 34'sd652032874;
  localparam logic [TEX_BITS:0]        TEX_ONE     = 17'd65536;

  typedef enum logic [2:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CENTER_Z      = 3'd2,
    REG_RADIUS        = 3'd3,
    REG_RING_COUNT    = 3'd4,
    REG_SECTION_COUNT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  function automatic logic signed [ANG_W-1:0] atan_turn(input int k);
    logic signed [ANG_W-1:0] a;
    case (k)
      0:  a = 33'sd536870912;
      1:  a = 33'sd316933405;
      2:  a = 33'sd167458907;
      3:  a = 33'sd85004756;
      4:  a = 33'sd42667331;
      5:  a = 33'sd21354465;
      6:  a = 33'sd10679838;
      7:  a = 33'sd5340245;
      8:  a = 33'sd2670163;
      9:  a = 33'sd1335086;
      10: a = 33'sd667544;
      11: a = 33'sd333772;
      12: a = 33'sd166886;
      13: a = 33'sd83443;
      14: a = 33'sd41721;
      15: a = 33'sd20860;
      16: a = 33'sd10430;
      17: a = 33'sd5215;
      18: a = 33'sd2607;
      19: a = 33'sd1303;
      20: a = 33'sd651;
      21: a = 33'sd325;
      22: a = 33'sd162;
      23: a = 33'sd81;
      24: a = 33'sd40;
      25: a = 33'sd20;
      26: a = 33'sd10;
      27: a = 33'sd5;
      28: a = 33'sd2;
      29: a = 33'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* sv/svg_divider.sv */
// Pipelined long divider: fraction num/den to 32 bits and a rounded 17-bit texture coordinate with 16 fraction bits.
// Depends on svg_pkg.
module svg_divider #(
  parameter int W = 8
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [W-1:0]                  num_i,
  input  logic [W-1:0]                  den_i,
  output logic [svg_pkg::FRAC_BITS:0]   quo_o,
  output logic [svg_pkg::TEX_BITS:0]    tex_o
);
  import svg_pkg::*;

  logic [W-1:0]         r_q   [0:DIV_STAGES];
  logic [FRAC_BITS:0]   q_q   [0:DIV_STAGES];
  logic [TEX_BITS:0]    tex_q [TEX_STAGE+1:DIV_STAGES];

  function automatic logic [W+DIV_STEP-1:0] div_step(input logic [W-1:0] r,
                                                     input logic [W-1:0] d);
    logic [W:0]          t;
    logic [W-1:0]        rr;
    logic [DIV_STEP-1:0] b;
    rr = r;
    b  = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      t = {rr, 1'b0};
      if (t >= {1'b0, d}) begin
        b[DIV_STEP-1-k] = 1'b1;
        rr = W'(t - {1'b0, d});
      end else begin
        rr = t[W-1:0];
      end
    end
    return {rr, b};
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (num_i >= den_i) begin
        r_q[0] <= num_i - den_i;
        q_q[0] <= {{FRAC_BITS{1'b0}}, 1'b1};
      end else begin
        r_q[0] <= num_i;
        q_q[0] <= '0;
      end
    end
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
    logic [W+DIV_STEP-1:0] step;
    assign step = div_step(r_q[s-1], den_i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= step[W+DIV_STEP-1:DIV_STEP];
        q_q[s] <= {q_q[s-1][FRAC_BITS-DIV_STEP:0], step[DIV_STEP-1:0]};
      end
    end
    if (s == TEX_STAGE + 1) begin : g_tex_round
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          tex_q[s] <= q_q[TEX_STAGE][TEX_BITS:0]
                    + {{TEX_BITS{1'b0}}, (r_q[TEX_STAGE] >= (den_i - (den_i >> 1)))};
        end
      end
    end else if (s > TEX_STAGE + 1) begin : g_tex_hold
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          tex_q[s] <= tex_q[s-1];
        end
      end
    end
  end

  assign quo_o = q_q[DIV_STAGES];
  assign tex_o = tex_q[DIV_STAGES];

endmodule

/* sv/svg_cordic.sv */
// Unrolled rotation-mode CORDIC: cosine and sine in Q30 of an angle in turn units.
// Depends on svg_pkg.
module svg_cordic #(
  parameter int STAGES = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [31:0]           ang_i,
  output svg_pkg::trig_t        trig_o
);
  import svg_pkg::*;

  logic signed [TRIG_W-1:0] x_q [0:STAGES-1];
  logic signed [TRIG_W-1:0] y_q [0:STAGES-1];
  logic signed [ANG_W-1:0]  z_q [0:STAGES-1];
  logic [1:0]               quad_q [0:STAGES-1];
  trig_t                    trig_q;

  for (genvar k = 0; k < STAGES; k++) begin : g_step
    logic signed [TRIG_W-1:0] sx, sy;
    logic signed [ANG_W-1:0]  sz;
    logic [1:0]               sq;
    if (k == 0) begin : g_first
      assign sx = CORDIC_INIT;
      assign sy = '0;
      assign sz = {3'b000, ang_i[29:0]};
      assign sq = ang_i[31:30];
    end else begin : g_next
      assign sx = x_q[k-1];
      assign sy = y_q[k-1];
      assign sz = z_q[k-1];
      assign sq = quad_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!sz[ANG_W-1]) begin
          x_q[k] <= sx - (sy >>> k);
          y_q[k] <= sy + (sx >>> k);
          z_q[k] <= sz - atan_turn(k);
        end else begin
          x_q[k] <= sx + (sy >>> k);
          y_q[k] <= sy - (sx >>> k);
          z_q[k] <= sz + atan_turn(k);
        end
        quad_q[k] <= sq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[STAGES-1])
        2'd0: begin
          trig_q.c <= x_q[STAGES-1];
          trig_q.s <= y_q[STAGES-1];
        end
        2'd1: begin
          trig_q.c <= -y_q[STAGES-1];
          trig_q.s <= x_q[STAGES-1];
        end
        2'd2: begin
          trig_q.c <= -x_q[STAGES-1];
          trig_q.s <= -y_q[STAGES-1];
        end
        default: begin
          trig_q.c <= y_q[STAGES-1];
          trig_q.s <= -x_q[STAGES-1];
        end
      endcase
    end
  end

  assign trig_o = trig_q;

endmodule

/* sv/svg_place.sv */
// Four-stage scaling: position from radius, angles and center; unit normal and tangent.
// Depends on svg_pkg.
module svg_place (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [30:0]         radius_i,
  input  logic signed [31:0]  center_x_i,
  input  logic signed [31:0]  center_y_i,
  input  logic signed [31:0]  center_z_i,
  input  svg_pkg::trig_t      theta_i,
  input  svg_pkg::trig_t      phi_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic signed [15:0]  normal_x_o,
  output logic signed [15:0]  normal_y_o,
  output logic signed [15:0]  normal_z_o,
  output logic signed [15:0]  tangent_x_o,
  output logic signed [15:0]  tangent_z_o
);
  import svg_pkg::*;

  function automatic logic signed [15:0] clamp_unit(input logic signed [23:0] v);
    if (v > 24'sd16384) return 16'sd16384;
    if (v < -24'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) return 32'sh7fffffff;
    if (v < -43'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // stage 1
  logic signed [67:0]       p_rst_q, p_rct_q, p_ss_q, p_sc_q;
  logic signed [TRIG_W-1:0] ct1_q, sp1_q, cp1_q;
  // stage 2
  logic signed [35:0]       rs_q, py_raw_q;
  logic signed [TRIG_W-1:0] sp2_q, cp2_q;
  logic signed [15:0]       nx2_q, ny2_q, nz2_q, tx2_q, tz2_q;
  // stage 3
  logic signed [71:0]       p_xs_q, p_xc_q;
  logic signed [35:0]       py3_q;
  logic signed [15:0]       nx3_q, ny3_q, nz3_q, tx3_q, tz3_q;

  logic signed [67:0]       sum_rst, sum_rct, sum_ss, sum_sc;
  logic signed [TRIG_W-1:0] sum_ct, sum_cp, sum_msp;
  logic signed [71:0]       sum_xs, sum_xc;
  logic signed [42:0]       px_d, py_d, pz_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rst_q <= $signed({1'b0, radius_i}) * theta_i.s;
      p_rct_q <= $signed({1'b0, radius_i}) * theta_i.c;
      p_ss_q  <= theta_i.s * phi_i.s;
      p_sc_q  <= theta_i.s * phi_i.c;
      ct1_q   <= theta_i.c;
      sp1_q   <= phi_i.s;
      cp1_q   <= phi_i.c;
    end
  end

  always_comb begin
    sum_rst = p_rst_q + (68'sd1 <<< 29);
    sum_rct = p_rct_q + (68'sd1 <<< 29);
    sum_ss  = p_ss_q + (68'sd1 <<< 45);
    sum_sc  = p_sc_q + (68'sd1 <<< 45);
    sum_ct  = ct1_q + 34'sd32768;
    sum_cp  = cp1_q + 34'sd32768;
    sum_msp = -sp1_q + 34'sd32768;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rs_q     <= $signed(sum_rst[65:30]);
      py_raw_q <= $signed(sum_rct[65:30]);
      nx2_q    <= clamp_unit(24'($signed(sum_ss[67:46])));
      nz2_q    <= clamp_unit(24'($signed(sum_sc[67:46])));
      ny2_q    <= clamp_unit(24'($signed(sum_ct[33:16])));
      tx2_q    <= clamp_unit(24'($signed(sum_cp[33:16])));
      tz2_q    <= clamp_unit(24'($signed(sum_msp[33:16])));
      sp2_q    <= sp1_q;
      cp2_q    <= cp1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_xs_q <= rs_q * sp2_q;
      p_xc_q <= rs_q * cp2_q;
      py3_q  <= py_raw_q;
      nx3_q  <= nx2_q;
      ny3_q  <= ny2_q;
      nz3_q  <= nz2_q;
      tx3_q  <= tx2_q;
      tz3_q  <= tz2_q;
    end
  end

  always_comb begin
    sum_xs = p_xs_q + (72'sd1 <<< 29);
    sum_xc = p_xc_q + (72'sd1 <<< 29);
    px_d   = 43'(center_x_i) + 43'($signed(sum_xs[71:30]));
    pz_d   = 43'(center_z_i) + 43'($signed(sum_xc[71:30]));
    py_d   = 43'(center_y_i) + 43'(py3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_x_o     <= sat32(px_d);
      pos_y_o     <= sat32(py_d);
      pos_z_o     <= sat32(pz_d);
      normal_x_o  <= nx3_q;
      normal_y_o  <= ny3_q;
      normal_z_o  <= nz3_q;
      tangent_x_o <= tx3_q;
      tangent_z_o <= tz3_q;
    end
  end

endmodule

/* sv/sphere_vertex_generator_core.sv */
// Top level of the UV-sphere vertex generator: config registers, pipeline control, output skid.
// Depends on svg_pkg, svg_divider, svg_cordic and svg_place.
//
//  channel | direction | handshake                  | beat
//  in      | sink      | in_valid_i / in_stall_o    | ring_index, section_index
//  out     | source    | out_valid_o / out_stall_i  | position, normal, tangent, texture, error
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | register index, 32-bit data
//
// One beat is accepted every clock while in_stall_o is low; the path runs through the
// 9-stage divider, the unrolled CORDIC and the 4-stage multiply chain.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// An output stall is absorbed by a one-beat skid; in_stall_o rises only when the skid is full.
module sphere_vertex_generator_core #(
  parameter int COUNT_BITS    = 8,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COUNT_BITS-1:0]  ring_index_i,
  input  logic [COUNT_BITS-1:0]  section_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [31:0]     pos_x_o,
  output logic signed [31:0]     pos_y_o,
  output logic signed [31:0]     pos_z_o,
  output logic signed [15:0]     normal_x_o,
  output logic signed [15:0]     normal_y_o,
  output logic signed [15:0]     normal_z_o,
  output logic signed [15:0]     tangent_x_o,
  output logic signed [15:0]     tangent_z_o,
  output logic [16:0]            tex_u_o,
  output logic [16:0]            tex_v_o,
  output logic                   index_error_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);
  import svg_pkg::*;

  localparam int CW      = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam int TEX_DLY = CORDIC_STAGES + 1 + PLACE_LAT;
  localparam int CTL_DLY = DIV_LAT + TEX_DLY;

  typedef struct packed {
    logic valid;
    logic err;
  } ctl_t;

  typedef struct packed {
    logic [TEX_BITS:0] ti;
    logic [TEX_BITS:0] tj;
  } tex_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               index_error;
  } beat_t;

  logic signed [31:0] center_x_q, center_y_q, center_z_q;
  logic [30:0]        radius_q;
  logic [CW-1:0]      ring_count_q, section_count_q;

  logic               en;
  logic               s0_valid_q;
  logic [CW-1:0]      i_q, j_q;
  logic               s0_err;

  logic [FRAC_BITS:0] ring_quo, sec_quo;
  logic [TEX_BITS:0]  ring_tex, sec_tex;
  trig_t              theta_trig, phi_trig;

  logic signed [31:0] px, py, pz;
  logic signed [15:0] nx, ny, nz, tx, tz;

  ctl_t               ctl_q [0:CTL_DLY-1];
  tex_t               tex_q [0:TEX_DLY-1];

  beat_t              pipe_beat;
  beat_t              main_q, skid_q;
  logic               main_valid_q, skid_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q      <= '0;
      center_y_q      <= '0;
      center_z_q      <= '0;
      radius_q        <= 31'd65536;
      ring_count_q    <= CW'(8);
      section_count_q <= CW'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CENTER_X:      center_x_q      <= cfg_data_i;
        REG_CENTER_Y:      center_y_q      <= cfg_data_i;
        REG_CENTER_Z:      center_z_q      <= cfg_data_i;
        REG_RADIUS:        radius_q        <= cfg_data_i[30:0];
        REG_RING_COUNT:    ring_count_q    <= CW'(cfg_data_i[COUNT_BITS-1:0]);
        REG_SECTION_COUNT: section_count_q <= CW'(cfg_data_i[COUNT_BITS-1:0]);
        default: ;
      endcase
    end
  end

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_q <= CW'(ring_index_i);
      j_q <= CW'(section_index_i);
    end
  end

  assign s0_err = (ring_count_q == '0) || (section_count_q == '0)
               || (i_q > ring_count_q) || (j_q > section_count_q);

  svg_divider #(.W(CW)) u_ring_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (i_q),
    .den_i (ring_count_q),
    .quo_o (ring_quo),
    .tex_o (ring_tex)
  );

  svg_divider #(.W(CW)) u_sec_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (j_q),
    .den_i (section_count_q),
    .quo_o (sec_quo),
    .tex_o (sec_tex)
  );

  svg_cordic #(.STAGES(CORDIC_STAGES)) u_theta (
    .clk_i  (clk_i),
    .en_i   (en),
    .ang_i  (ring_quo[FRAC_BITS:1]),
    .trig_o (theta_trig)
  );

  svg_cordic #(.STAGES(CORDIC_STAGES)) u_phi (
    .clk_i  (clk_i),
    .en_i   (en),
    .ang_i  (sec_quo[FRAC_BITS-1:0]),
    .trig_o (phi_trig)
  );

  svg_place u_place (
    .clk_i       (clk_i),
    .en_i        (en),
    .radius_i    (radius_q),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .center_z_i  (center_z_q),
    .theta_i     (theta_trig),
    .phi_i       (phi_trig),
    .pos_x_o     (px),
    .pos_y_o     (py),
    .pos_z_o     (pz),
    .normal_x_o  (nx),
    .normal_y_o  (ny),
    .normal_z_o  (nz),
    .tangent_x_o (tx),
    .tangent_z_o (tz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CTL_DLY; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= '{valid: s0_valid_q, err: s0_err};
      for (int k = 1; k < CTL_DLY; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tex_q[0] <= '{ti: ring_tex, tj: sec_tex};
      for (int k = 1; k < TEX_DLY; k++) begin
        tex_q[k] <= tex_q[k-1];
      end
    end
  end

  always_comb begin
    pipe_beat = '0;
    if (ctl_q[CTL_DLY-1].err) begin
      pipe_beat.index_error = 1'b1;
    end else begin
      pipe_beat.pos_x     = px;
      pipe_beat.pos_y     = py;
      pipe_beat.pos_z     = pz;
      pipe_beat.normal_x  = nx;
      pipe_beat.normal_y  = ny;
      pipe_beat.normal_z  = nz;
      pipe_beat.tangent_x = tx;
      pipe_beat.tangent_z = tz;
      pipe_beat.tex_u     = TEX_ONE - tex_q[TEX_DLY-1].tj;
      pipe_beat.tex_v     = tex_q[TEX_DLY-1].ti;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_valid_q && out_stall_i) begin
      if (en && ctl_q[CTL_DLY-1].valid) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      main_valid_q <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= ctl_q[CTL_DLY-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_valid_q && out_stall_i) begin
      if (en) begin
        skid_q <= pipe_beat;
      end
    end else if (skid_valid_q) begin
      main_q <= skid_q;
    end else begin
      main_q <= pipe_beat;
    end
  end

  assign out_valid_o   = main_valid_q;
  assign pos_x_o       = main_q.pos_x;
  assign pos_y_o       = main_q.pos_y;
  assign pos_z_o       = main_q.pos_z;
  assign normal_x_o    = main_q.normal_x;
  assign normal_y_o    = main_q.normal_y;
  assign normal_z_o    = main_q.normal_z;
  assign tangent_x_o   = main_q.tangent_x;
  assign tangent_z_o   = main_q.tangent_z;
  assign tex_u_o       = main_q.tex_u;
  assign tex_v_o       = main_q.tex_v;
  assign index_error_o = main_q.index_error;

  a_skid_needs_main : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid holds a beat while the output register is empty");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_stall_i |=> main_valid_q && !skid_valid_q)
    else $error("skid beat not moved to the output register");

  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_valid_q && main_q.index_error |-> main_q.pos_x == '0 && main_q.pos_y == '0
      && main_q.pos_z == '0 && main_q.tex_u == '0 && main_q.tex_v == '0)
    else $error("error beat carries nonzero payload");

  a_tex_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_valid_q |-> main_q.tex_u <= TEX_ONE && main_q.tex_v <= TEX_ONE)
    else $error("texture coordinate above one");

endmodule

/* sim/testbench.sv */
// Self-checking bench for sphere_vertex_generator_core: directed table, then random grid points.
// Predicts every vertex with its own CORDIC model; depends on svg_pkg and the core.
`timescale 1ns / 100ps
module testbench;
  import svg_pkg::*;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int STAGES  = 16;
  localparam int LATENCY = STAGES + 16;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz, tx, tz;
    logic [16:0]        u, v;
    logic               err;
  } vertex_t;

  typedef struct {
    logic [7:0] ring, sect;
    bit         is_err;
  } row_t;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0, cfg_valid_i = 0;
  logic [7:0] ring_index_i = '0, section_index_i = '0;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_stall_o, out_valid_o, cfg_ready_o, index_error_o;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o, tangent_x_o, tangent_z_o;
  logic [16:0] tex_u_o, tex_v_o;

  logic signed [31:0] c_x = 0, c_y = 0, c_z = 0;
  logic [30:0] c_rad = 31'd65536;
  logic [7:0]  c_rings = 8'd8, c_sects = 8'd8;

  vertex_t vertex_q[$];
  int errors = 0, n_sent = 0, n_checked = 0, n_err_beats = 0;
  bit calm = 0;

  sphere_vertex_generator_core uut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint atan_at(int k);
    longint t[16] = '{536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886,
                      83443, 41721, 20860};
    return t[k];
  endfunction

  function automatic void sin_cos(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(ang[29:0]);
    for (int k = 0; k < STAGES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_at(k);
      end else begin
        x += dx; y -= dy; z += atan_at(k);
      end
    end
    case (ang[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint clamp_unit(longint v);
    return v > 16384 ? 16384 : (v < -16384 ? -16384 : v);
  endfunction

  function automatic longint sat_pos(longint v);
    return v > 64'sd2147483647 ? 64'sd2147483647 :
           (v < -64'sd2147483648 ? -64'sd2147483648 : v);
  endfunction

  function automatic vertex_t vertex_of(logic [7:0] i, logic [7:0] j);
    vertex_t r;
    longint ct, st, cp, sp, rs;
    longint ri, rr, sj, ss;
    logic [31:0] theta, phi;
    r = '0;
    ri = i; rr = c_rings; sj = j; ss = c_sects;
    if (rr == 0 || ss == 0 || ri > rr || sj > ss) begin
      r.err = 1'b1;
      return r;
    end
    theta = 32'((ri <<< 31) / rr);
    phi   = 32'((sj <<< 32) / ss);
    sin_cos(theta, ct, st);
    sin_cos(phi, cp, sp);
    rs = (longint'(c_rad) * st + 64'sd536870912) >>> 30;
    r.px = 32'(sat_pos(longint'(c_x) + ((rs * sp + 64'sd536870912) >>> 30)));
    r.py = 32'(sat_pos(longint'(c_y) + ((longint'(c_rad) * ct + 64'sd536870912) >>> 30)));
    r.pz = 32'(sat_pos(longint'(c_z) + ((rs * cp + 64'sd536870912) >>> 30)));
    r.nx = 16'(clamp_unit((st * sp + (64'sd1 <<< 45)) >>> 46));
    r.ny = 16'(clamp_unit((ct + 32768) >>> 16));
    r.nz = 16'(clamp_unit((st * cp + (64'sd1 <<< 45)) >>> 46));
    r.tx = 16'(clamp_unit((cp + 32768) >>> 16));
    r.tz = 16'(clamp_unit((-sp + 32768) >>> 16));
    r.u  = 17'(65536 - (sj * 65536 + ss / 2) / ss);
    r.v  = 17'((ri * 65536 + rr / 2) / rr);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (vertex_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual pos %h %h %h", $realtime,
                 pos_x_o, pos_y_o, pos_z_o);
      end else begin
        e = vertex_q.pop_front();
        n_checked++;
        if (e.err) n_err_beats++;
        check_field("pos_x", e.px, pos_x_o);
        check_field("pos_y", e.py, pos_y_o);
        check_field("pos_z", e.pz, pos_z_o);
        check_field("normal_x", 32'(e.nx), 32'(normal_x_o));
        check_field("normal_y", 32'(e.ny), 32'(normal_y_o));
        check_field("normal_z", 32'(e.nz), 32'(normal_z_o));
        check_field("tangent_x", 32'(e.tx), 32'(tangent_x_o));
        check_field("tangent_z", 32'(e.tz), 32'(tangent_z_o));
        check_field("tex_u", 32'(e.u), 32'(tex_u_o));
        check_field("tex_v", 32'(e.v), 32'(tex_v_o));
        check_field("index_error", 32'(e.err), 32'(index_error_o));
      end
    end
  end

  // output stall: random hold per beat, none during calm stretches
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send(logic [7:0] i, logic [7:0] j, bit typed_err);
    int gap;
    vertex_t e;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ring_index_i <= i;
    section_index_i <= j;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (typed_err) begin
      e = '0;
      e.err = 1'b1;
    end else begin
      e = vertex_of(i, j);
    end
    vertex_q.push_back(e);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_config(logic [31:0] cx, cy, cz, rad, rings, sects);
    logic [2:0]  idx[8];
    logic [31:0] dat[8];
    idx = '{REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z, REG_RADIUS, REG_RING_COUNT,
            REG_SECTION_COUNT, REG_SPARE_A, REG_SPARE_B};
    dat = '{cx, cy, cz, rad, rings, sects, $urandom, $urandom};
    for (int k = 0; k < 8; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= dat[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    c_x = cx; c_y = cy; c_z = cz;
    c_rad = rad[30:0];
    c_rings = rings[7:0];
    c_sects = sects[7:0];
  endtask

  task automatic random_items(int count);
    logic [7:0] i, j;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15) begin
        i = 8'($urandom);
        j = 8'($urandom);
      end else begin
        i = 8'($urandom_range(0, c_rings));
        j = 8'($urandom_range(0, c_sects));
      end
      send(i, j, 1'b0);
    end
    calm = 0;
  endtask

  initial begin
    row_t rows[$];
    rows = '{'{8'd0, 8'd0, 0}, '{8'd8, 8'd0, 0}, '{8'd0, 8'd8, 0}, '{8'd8, 8'd8, 0},
             '{8'd4, 8'd2, 0}, '{8'd1, 8'd7, 0}, '{8'd7, 8'd1, 0}, '{8'd3, 8'd5, 0},
             '{8'd9, 8'd0, 1}, '{8'd0, 8'd9, 1}, '{8'd255, 8'd255, 1}, '{8'd255, 8'd0, 1},
             '{8'd0, 8'd255, 1}, '{8'd2, 8'd4, 0}, '{8'd6, 8'd6, 0}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) send(rows[r].ring, rows[r].sect, rows[r].is_err);
    random_items(100);
    drain();

    write_config(0, 0, 0, 0, 8, 8);
    random_items(120);
    drain();
    write_config(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff, 255, 255);
    random_items(150);
    drain();
    write_config(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffff01, 1);
    random_items(100);
    drain();
    write_config(0, 0, 0, 65536, 0, 5);
    random_items(40);
    drain();
    write_config(0, 0, 0, 65536, 7, 0);
    random_items(40);
    drain();
    for (int p = 0; p < 7; p++) begin
      write_config($urandom, $urandom, $urandom,
                   p % 2 ? $urandom : $urandom_range(0, 32'h00ffffff),
                   {24'($urandom_range(0, 32'hffffff)), 8'($urandom_range(1, 255))},
                   {24'($urandom_range(0, 32'hffffff)), 8'($urandom_range(1, 255))});
      random_items(130);
      drain();
    end

    $display("Covered %0d grid points over 13 register settings, %0d beats checked,",
             n_sent, n_checked);
    $display("%0d of them index errors; %0d mismatches.", n_err_beats, errors);
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("sphere_vertex_generator_core test passed");
    end else begin
      $display("sphere_vertex_generator_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d beats outstanding.", vertex_q.size());
    $display("sphere_vertex_generator_core test failed");
    $finish;
  end

endmodule
